// ----- rtl/core/frv_pkg.sv -----
// Shared constants and types for the frame reorder and release block.
package frv_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int STORE_SLOTS     = 8;
  localparam int STORE_W         = 3;
  localparam int REPEAT_ADVANCE  = 4;
  localparam int DIDX_W          = 16;
  localparam int WORD_W          = 32;
  localparam int ALU_W           = WORD_W + 1;
  localparam int IN_TDATA_W      = 96;
  localparam int IN_TUSER_W      = 3;
  localparam int OUT_TDATA_W     = 128;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VBV_ENABLE = 2'd0,
    CFG_VBV_SIZE   = 2'd1,
    CFG_VBV_BPF    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic             neg;
    logic [ALU_W-1:0] val;
  } alu_res_t;

  typedef struct packed {
    logic [WORD_W-1:0]      disp;
    logic [WORD_W-1:0]      bits;
    logic                   key;
    logic                   shown;
    logic                   rep;
    logic [STORE_W-1:0]     eslot;
    logic [STORE_SLOTS-1:0] refresh;
  } slot_entry_t;

endpackage

// ----- rtl/core/frame_reorder_release_vbv.sv -----
// Top level: frame reorder queue with in-order release, continuity check and fill tracking.
//
// Input channel in_*: one finished frame descriptor per item. in_tready is high only
// while the sequencer is idle. The slot index (decode_index mod QUEUE_DEPTH) is found
// by a reciprocal multiplication that gives the quotient, then the shared add/subtract
// unit takes quotient times depth off the index; then the slot memory is written.
// Release: every consecutive valid slot from the head is read and sent out; each
// released frame passes through memory read, continuity check and fill subtract, fill
// add, cap and output load, each fill step one pass through the shared unit.
// out_tlast marks the last release caused by an item.
// Output channel out_*: one registered result. When the receiver stalls, the sequencer
// holds in its cap step until the output register is free; after the last result the
// block takes a new item even while that result still waits.
// Configuration: cfg_we writes register cfg_index (0 enable, 1 size, 2 bits per frame);
// other indexes are ignored. Write only while idle.
// Reset (rst_n low, synchronous) empties the queue, zeroes head, counters, fill,
// picture store and configuration registers. No clearing pass is needed.
module frame_reorder_release_vbv #(
  parameter int QUEUE_DEPTH = frv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: decode_index[15:0], display_order[47:16], frame_bits[79:48],
  //           existing_slot[82:80], refresh_slots[90:83], zero[95:91]
  input  logic [frv_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: is_key[0], is_shown[1], repeats_existing[2]
  input  logic [frv_pkg::IN_TUSER_W-1:0]       in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: out_display_order[31:0], out_bits[63:32], fill_level[95:64],
  //            shown_count[127:96]
  output logic [frv_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: order_error[0]
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [frv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frv_pkg::WORD_W-1:0]           cfg_wdata
);

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int W      = frv_pkg::WORD_W;
  localparam int MOD_SH = frv_pkg::DIDX_W + SLOT_W;
  localparam int QP_W   = 2 * frv_pkg::DIDX_W + 1;
  localparam longint RECIP = ((longint'(1) << MOD_SH) + longint'(QUEUE_DEPTH) - longint'(1))
                             / longint'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_REM,
    ST_WRITE,
    ST_CHECK,
    ST_LOAD,
    ST_ADD,
    ST_CAP
  } state_t;

  state_t                          state_r;
  logic [frv_pkg::DIDX_W-1:0]      didx_r;
  logic [frv_pkg::DIDX_W-1:0]      quot_r;
  logic [SLOT_W-1:0]               mod_r;
  frv_pkg::slot_entry_t            entry_r;
  logic [QUEUE_DEPTH-1:0]          valid_r;
  logic [SLOT_W-1:0]               head_r;
  logic [W-1:0]                    next_disp_r;
  logic [W-1:0]                    shown_r;
  logic [W-1:0]                    store_r [frv_pkg::STORE_SLOTS];
  logic [W-1:0]                    fill_r;
  logic [W-1:0]                    t_r;
  logic [frv_pkg::ALU_W-1:0]       sum_r;
  logic                            err_r;
  logic                            vbv_en_r;
  logic [W-1:0]                    vbv_size_r;
  logic [W-1:0]                    vbv_bpf_r;
  logic [frv_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                            out_tuser_r;
  logic                            out_tlast_r;
  logic                            out_tvalid_r;

  frv_pkg::alu_op_t                alu_op;
  logic [frv_pkg::ALU_W-1:0]       alu_a;
  logic [frv_pkg::ALU_W-1:0]       alu_b;
  frv_pkg::alu_res_t               alu_res;

  frv_pkg::slot_entry_t            rd;
  logic                            ram_we;
  logic                            ram_re;
  logic [QP_W-1:0]                 quot_prod;
  logic [frv_pkg::DIDX_W-1:0]      quot_mul;
  logic [SLOT_W-1:0]               head_nxt;
  logic                            last_nxt;
  logic                            emit;
  logic                            shown_ok;
  logic                            rep_ok;
  logic [W-1:0]                    nd1;
  logic [W-1:0]                    next_disp_nxt;
  logic                            err_nxt;
  logic [W-1:0]                    shown_nxt;
  logic [W-1:0]                    fill_cap;
  logic [W-1:0]                    fill_nxt;

  frv_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  frv_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (mod_r),
    .wdata (entry_r),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (rd)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_tvalid = out_tvalid_r;

  // Rounded-up reciprocal gives the exact quotient for every 16-bit index.
  assign quot_prod = QP_W'(didx_r) * QP_W'(RECIP);
  assign quot_mul  = quot_r * frv_pkg::DIDX_W'(QUEUE_DEPTH);
  assign ram_we    = (state_r == ST_WRITE);
  assign ram_re    = (state_r == ST_CHECK) && valid_r[head_r];
  assign head_nxt  = (head_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign last_nxt  = !valid_r[head_nxt];
  assign emit      = (state_r == ST_CAP) && (!out_tvalid_r || out_tready);

  // Shared unit operand select, one use per sequencer step.
  always_comb begin
    case (state_r)
      ST_REM: begin
        alu_op = frv_pkg::ALU_SUB;
        alu_a  = frv_pkg::ALU_W'(didx_r);
        alu_b  = frv_pkg::ALU_W'(quot_mul);
      end
      ST_LOAD: begin
        alu_op = frv_pkg::ALU_SUB;
        alu_a  = {1'b0, fill_r};
        alu_b  = {1'b0, rd.bits};
      end
      ST_ADD: begin
        alu_op = frv_pkg::ALU_ADD;
        alu_a  = {1'b0, t_r};
        alu_b  = {1'b0, vbv_bpf_r};
      end
      ST_CAP: begin
        alu_op = frv_pkg::ALU_SUB;
        alu_a  = sum_r;
        alu_b  = {1'b0, vbv_size_r};
      end
      default: begin
        alu_op = frv_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
      end
    endcase
  end

  // Display continuity: shown check first, then repeat check against the store.
  always_comb begin
    shown_ok      = rd.shown && (rd.disp == next_disp_r);
    nd1           = shown_ok ? next_disp_r + 1'b1 : next_disp_r;
    rep_ok        = rd.rep && (store_r[rd.eslot] == nd1);
    next_disp_nxt = rep_ok ? nd1 + W'(frv_pkg::REPEAT_ADVANCE) : nd1;
    err_nxt       = (rd.shown && !shown_ok) || (rd.rep && !rep_ok);
    shown_nxt     = shown_r + W'(rd.shown)
                  + (rd.rep ? W'(frv_pkg::REPEAT_ADVANCE) : W'(0));
  end

  // Cap at size when the sum reaches it; leave fill alone when tracking is off or size is 0.
  always_comb begin
    fill_cap = alu_res.neg ? sum_r[W-1:0] : vbv_size_r;
    fill_nxt = (vbv_en_r && (vbv_size_r != '0)) ? fill_cap : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      head_r       <= '0;
      next_disp_r  <= '0;
      shown_r      <= '0;
      fill_r       <= '0;
      vbv_en_r     <= 1'b0;
      vbv_size_r   <= '0;
      vbv_bpf_r    <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < frv_pkg::STORE_SLOTS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          frv_pkg::CFG_VBV_ENABLE: vbv_en_r   <= cfg_wdata[0];
          frv_pkg::CFG_VBV_SIZE:   vbv_size_r <= cfg_wdata;
          frv_pkg::CFG_VBV_BPF:    vbv_bpf_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready && !emit) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            didx_r        <= in_tdata[15:0];
            entry_r.disp  <= in_tdata[47:16];
            entry_r.bits  <= in_tdata[79:48];
            entry_r.eslot <= in_tdata[82:80];
            entry_r.refresh <= in_tdata[90:83];
            entry_r.key   <= in_tuser[0];
            entry_r.shown <= in_tuser[1];
            entry_r.rep   <= in_tuser[2];
            mod_r         <= '0;
            state_r       <= ST_MOD;
          end
        end
        ST_MOD: begin
          quot_r  <= frv_pkg::DIDX_W'(quot_prod >> MOD_SH);
          state_r <= ST_REM;
        end
        ST_REM: begin
          // Remainder is below the depth, so the low bits of the difference hold it.
          mod_r   <= alu_res.val[SLOT_W-1:0];
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          valid_r[mod_r] <= 1'b1;
          state_r        <= ST_CHECK;
        end
        ST_CHECK: begin
          state_r <= valid_r[head_r] ? ST_LOAD : ST_IDLE;
        end
        ST_LOAD: begin
          next_disp_r <= next_disp_nxt;
          shown_r     <= shown_nxt;
          err_r       <= err_nxt;
          t_r         <= alu_res.neg ? '0 : alu_res.val[W-1:0];
          for (int i = 0; i < frv_pkg::STORE_SLOTS; i++) begin
            if (rd.key || rd.refresh[i]) begin
              store_r[i] <= rd.disp;
            end
          end
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          sum_r   <= alu_res.val;
          state_r <= ST_CAP;
        end
        ST_CAP: begin
          if (emit) begin
            fill_r          <= fill_nxt;
            out_tdata_r     <= {shown_r, fill_nxt, rd.bits, rd.disp};
            out_tuser_r     <= err_r;
            out_tlast_r     <= last_nxt;
            out_tvalid_r    <= 1'b1;
            valid_r[head_r] <= 1'b0;
            head_r          <= head_nxt;
            state_r         <= last_nxt ? ST_IDLE : ST_CHECK;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD || state_r == ST_WRITE)
      |-> ((SLOT_W + 1)'(mod_r) < (SLOT_W + 1)'(QUEUE_DEPTH)))
    else $error("slot index out of queue range");

  a_release_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD || emit) |-> valid_r[head_r])
    else $error("release of an empty slot");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_nxt) |=> (!valid_r[head_r] && state_r == ST_IDLE))
    else $error("last release left a valid head slot");

endmodule

// ----- rtl/core/frv_alu.sv -----
// Shared add/subtract unit with sign output, used for slot modulo and fill update.
module frv_alu (
  input  frv_pkg::alu_op_t              op,
  input  logic [frv_pkg::ALU_W-1:0]     a,
  input  logic [frv_pkg::ALU_W-1:0]     b,
  output frv_pkg::alu_res_t             res
);

  logic [frv_pkg::ALU_W:0] sum;

  always_comb begin
    if (op == frv_pkg::ALU_SUB) begin
      sum = {1'b0, a} - {1'b0, b};
    end else begin
      sum = {1'b0, a} + {1'b0, b};
    end
    res.neg = sum[frv_pkg::ALU_W];
    res.val = sum[frv_pkg::ALU_W-1:0];
  end

endmodule

// ----- rtl/core/frv_slot_ram.sv -----
// Reorder slot memory: one write port, one registered read port.
module frv_slot_ram #(
  parameter int DEPTH = frv_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(frv_pkg::QUEUE_DEPTH_DEF)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  frv_pkg::slot_entry_t  wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output frv_pkg::slot_entry_t  rdata
);

  frv_pkg::slot_entry_t mem [DEPTH];
  frv_pkg::slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
